// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the filter block.
// Depends on nothing; included by the files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define CFIR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Clocked assertion that also holds through reset.
`define CFIR_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

// ===== rtl/cfir_pkg.sv =====
// Shared types and constants of the centred FIR filter.
// Used by the controller, the datapath, the top level and the checker.
package cfir_pkg;

   localparam int MAX_TAPS_DEF  = 1024;
   localparam int COEF_BITS_DEF = 18;

   localparam int SAMPLE_W    = 16;
   localparam int COEF_IN_W   = 18;
   localparam int INDEX_W     = 10;
   localparam int TAPS_CFG_W  = 10;
   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 16;

   localparam logic [TAPS_CFG_W-1:0] TAPS_CFG_RESET = 10'd3;
   localparam logic [9:0]            COUNT_MAX      = 10'd1023;

   typedef enum logic [1:0] {
      ACT_LOAD   = 2'd0,
      ACT_START  = 2'd1,
      ACT_SAMPLE = 2'd2,
      ACT_PAD    = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic load_coef;
      logic start_rec;
      logic shift_in;
      logic acc_clear;
      logic issue;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic                  emit;
      logic                  pipe_busy;
      logic [TAPS_CFG_W-1:0] taps;
   } status_type;

endpackage

// ===== rtl/cfir_ctrl.sv =====
// Sequencer of the centred FIR filter: handshakes, tap walk and result hand-off.
// Depends on cfir_pkg; drives cfir_datapath through command and status structs.
module cfir_ctrl #(
   parameter int MAX_TAPS = cfir_pkg::MAX_TAPS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  cfir_pkg::action_type   action,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  cfir_pkg::status_type   status,
   output cfir_pkg::cmd_type      cmd,
   output logic [$clog2(MAX_TAPS)-1:0] tap_idx
);

   localparam int TAP_W = $clog2(MAX_TAPS);

   cfir_pkg::state_type state_ff, state_in;
   logic [TAP_W-1:0]    k_ff, k_in;
   logic                rsp_tvalid_ff, rsp_tvalid_in;
   logic                last_tap;

   assign last_tap   = (32'(k_ff) + 32'd1 == 32'(status.taps));
   assign tap_idx    = k_ff;
   assign rsp_tvalid = rsp_tvalid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= cfir_pkg::ST_IDLE;
         k_ff          <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         k_ff          <= k_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      k_in       = k_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         cfir_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               unique case (action) inside
                  cfir_pkg::ACT_LOAD: begin
                     cmd.load_coef = 1'b1;
                  end
                  cfir_pkg::ACT_START: begin
                     cmd.start_rec = 1'b1;
                  end
                  cfir_pkg::ACT_SAMPLE, cfir_pkg::ACT_PAD: begin
                     cmd.shift_in = 1'b1;
                     if (status.emit) begin
                        cmd.acc_clear = 1'b1;
                        k_in          = '0;
                        // With no taps in use the sum is simply zero.
                        state_in = (status.taps == '0) ? cfir_pkg::ST_DRAIN
                                                       : cfir_pkg::ST_RUN;
                     end
                  end
                  default: begin
                     state_in = cfir_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         cfir_pkg::ST_RUN: begin
            cmd.issue = 1'b1;
            if (last_tap) begin
               state_in = cfir_pkg::ST_DRAIN;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         cfir_pkg::ST_DRAIN: begin
            if (!status.pipe_busy && (!rsp_tvalid_ff || rsp_tready)) begin
               cmd.out_load = 1'b1;
               state_in     = cfir_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cfir_pkg::ST_IDLE;
         end
      endcase
      if (cmd.out_load) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end else begin
         rsp_tvalid_in = rsp_tvalid_ff;
      end
   end

endmodule

// ===== rtl/cfir_datapath.sv =====
// Datapath of the centred FIR filter: coefficient and delay-line memories,
// shared multiply-accumulate, rounding and saturation. Depends on cfir_pkg.
module cfir_datapath #(
   parameter int MAX_TAPS  = cfir_pkg::MAX_TAPS_DEF,
   parameter int COEF_BITS = cfir_pkg::COEF_BITS_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      csr_we,
   input  logic        [cfir_pkg::TAPS_CFG_W-1:0]    csr_wdata,
   input  logic        [cfir_pkg::INDEX_W-1:0]       coef_index,
   input  logic signed [cfir_pkg::COEF_IN_W-1:0]     coef_value,
   input  logic signed [cfir_pkg::SAMPLE_W-1:0]      sample,
   input  cfir_pkg::action_type                      action,
   input  cfir_pkg::cmd_type                         cmd,
   input  logic        [$clog2(MAX_TAPS)-1:0]        tap_idx,
   output cfir_pkg::status_type                      status,
   output logic signed [cfir_pkg::SAMPLE_W-1:0]      filtered,
   output logic                                      saturated
);

   localparam int TAP_W  = $clog2(MAX_TAPS);
   localparam int FILL_W = $clog2(MAX_TAPS + 1);
   localparam int PROD_W = COEF_BITS + cfir_pkg::SAMPLE_W;
   localparam int ACC_W  = PROD_W + TAP_W + 1;
   localparam int RND_W  = ACC_W - 15;
   localparam logic signed [RND_W-1:0] SAT_HI = RND_W'(32767);
   localparam logic signed [RND_W-1:0] SAT_LO = RND_W'(-32768);

   logic signed [COEF_BITS-1:0]          coef_mem [MAX_TAPS];
   logic signed [cfir_pkg::SAMPLE_W-1:0] delay_mem [MAX_TAPS];

   logic [cfir_pkg::TAPS_CFG_W-1:0]  taps_cfg_ff;
   logic [TAP_W-1:0]                 newest_ff;
   logic [TAP_W-1:0]                 rd_slot_ff;
   logic [FILL_W-1:0]                fill_ff;
   logic [9:0]                       items_ff;

   logic signed [COEF_BITS-1:0]          coef_rd_ff;
   logic signed [cfir_pkg::SAMPLE_W-1:0] samp_rd_ff;
   logic                                 live_rd_ff;
   logic                                 rd_v_ff;
   logic signed [PROD_W-1:0]             prod_ff;
   logic                                 prod_v_ff;
   logic signed [ACC_W-1:0]              acc_ff;
   logic signed [cfir_pkg::SAMPLE_W-1:0] filtered_ff;
   logic                                 saturated_ff;

   logic [cfir_pkg::TAPS_CFG_W-1:0]      taps;
   logic [cfir_pkg::TAPS_CFG_W-1:0]      center;
   logic [TAP_W-1:0]                     nxt_pos;
   logic signed [31:0]                   coef_ext;
   logic signed [cfir_pkg::SAMPLE_W-1:0] shift_val;
   logic signed [cfir_pkg::SAMPLE_W-1:0] mul_samp;
   logic signed [ACC_W:0]                rnd_sum;
   logic signed [RND_W-1:0]              rnd_q;
   logic                                 coef_in_range;

   // Taps in use are limited to the depth of the stores.
   assign taps   = (32'(taps_cfg_ff) > MAX_TAPS) ? cfir_pkg::TAPS_CFG_W'(MAX_TAPS)
                                                 : taps_cfg_ff;
   assign center = taps >> 1;

   assign status.taps      = taps;
   assign status.emit      = !(items_ff < center);
   assign status.pipe_busy = rd_v_ff || prod_v_ff;

   assign nxt_pos = (32'(newest_ff) + 32'd1 >= MAX_TAPS) ? '0 : newest_ff + 1'b1;

   assign coef_ext      = 32'(coef_value);
   assign coef_in_range = (32'(coef_index) < MAX_TAPS);
   assign shift_val     = (action == cfir_pkg::ACT_SAMPLE) ? sample : '0;

   // Slots not written since the record began read as zero.
   assign mul_samp = live_rd_ff ? samp_rd_ff : '0;

   assign rnd_sum = (ACC_W+1)'(acc_ff) + (ACC_W+1)'(32'sd32768);
   assign rnd_q   = rnd_sum[ACC_W:16];

   assign filtered  = filtered_ff;
   assign saturated = saturated_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_coef && coef_in_range) begin
         coef_mem[TAP_W'(coef_index)] <= coef_ext[COEF_BITS-1:0];
      end
      if (cmd.issue) begin
         coef_rd_ff <= coef_mem[tap_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.shift_in) begin
         delay_mem[nxt_pos] <= shift_val;
      end
      if (cmd.issue) begin
         samp_rd_ff <= delay_mem[rd_slot_ff];
         live_rd_ff <= (32'(tap_idx) < 32'(fill_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         taps_cfg_ff <= cfir_pkg::TAPS_CFG_RESET;
         newest_ff   <= '0;
         fill_ff     <= '0;
         items_ff    <= '0;
         rd_v_ff     <= 1'b0;
         prod_v_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            taps_cfg_ff <= csr_wdata;
         end
         if (cmd.start_rec) begin
            newest_ff <= '0;
            fill_ff   <= '0;
            items_ff  <= '0;
         end else if (cmd.shift_in) begin
            newest_ff <= nxt_pos;
            if (32'(fill_ff) < MAX_TAPS) begin
               fill_ff <= fill_ff + 1'b1;
            end
            if (items_ff < cfir_pkg::COUNT_MAX) begin
               items_ff <= items_ff + 1'b1;
            end
         end
         rd_v_ff   <= cmd.issue;
         prod_v_ff <= rd_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.acc_clear) begin
         rd_slot_ff <= nxt_pos;
      end else if (cmd.issue) begin
         rd_slot_ff <= (rd_slot_ff == '0) ? TAP_W'(MAX_TAPS - 1) : rd_slot_ff - 1'b1;
      end
      prod_ff <= coef_rd_ff * mul_samp;
      if (cmd.acc_clear) begin
         acc_ff <= '0;
      end else if (prod_v_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
      if (cmd.out_load) begin
         if (rnd_q > SAT_HI) begin
            filtered_ff  <= 16'sh7fff;
            saturated_ff <= 1'b1;
         end else if (rnd_q < SAT_LO) begin
            filtered_ff  <= -16'sh8000;
            saturated_ff <= 1'b1;
         end else begin
            filtered_ff  <= rnd_q[cfir_pkg::SAMPLE_W-1:0];
            saturated_ff <= 1'b0;
         end
      end
   end

endmodule

// ===== rtl/centered_fir_filter.sv =====
// A sample that yields a result walks every tap in use through the single multiply-accumulate
// (none with no taps in use), then waits for the pipeline to empty and the previous result
// to be taken before its result is registered; no new request is accepted until then.
// Load, start and warm-up items are accepted while idle and leave the sequencer idle.
// Reset is synchronous and active high: three taps, empty record, no result pending;
// the coefficient store holds whatever was last written.
module centered_fir_filter #(
   parameter int MAX_TAPS  = cfir_pkg::MAX_TAPS_DEF,
   parameter int COEF_BITS = cfir_pkg::COEF_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // Low bit up: coef_index[9:0], coef_value[27:10], sample[43:28], zero fill.
   input  logic [cfir_pkg::REQ_DATA_W-1:0]        req_tdata,
   // action[1:0]
   input  logic [1:0]                             req_tuser,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // filtered[15:0]
   output logic [cfir_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   // saturated[0]
   output logic [0:0]                             rsp_tuser,
   input  logic                                   csr_we,
   input  logic [cfir_pkg::TAPS_CFG_W-1:0]        csr_wdata
);

   localparam int TAP_W = $clog2(MAX_TAPS);

   cfir_pkg::cmd_type    cmd;
   cfir_pkg::status_type status;
   cfir_pkg::action_type action;
   logic [TAP_W-1:0]     tap_idx;
   logic signed [cfir_pkg::SAMPLE_W-1:0] filtered;
   logic                 saturated;

   assign action = cfir_pkg::action_type'(req_tuser);

   cfir_ctrl #(
      .MAX_TAPS (MAX_TAPS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .action     (action),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd),
      .tap_idx    (tap_idx)
   );

   cfir_datapath #(
      .MAX_TAPS  (MAX_TAPS),
      .COEF_BITS (COEF_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .coef_index (req_tdata[9:0]),
      .coef_value (req_tdata[27:10]),
      .sample     (req_tdata[43:28]),
      .action     (action),
      .cmd        (cmd),
      .tap_idx    (tap_idx),
      .status     (status),
      .filtered   (filtered),
      .saturated  (saturated)
   );

   assign rsp_tdata    = filtered;
   assign rsp_tuser[0] = saturated;

endmodule

// ===== rtl/cfir_checker.sv =====
// Port-level checks on the centred FIR filter, bound to the top level.
// Depends on cfir_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cfir_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [1:0]                          req_tuser,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [cfir_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input logic [0:0]                          rsp_tuser
);

   // A pending result stays offered until it is taken.
   `CFIR_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "result dropped before transaction")

   // A saturated result carries one of the two range limits.
   `CFIR_ASSERT(a_sat_limit, clock, reset, rsp_tvalid && rsp_tuser[0] |-> (rsp_tdata == 16'h7fff || rsp_tdata == 16'h8000), "saturated result not at a limit")

   // No result is pending in the cycle after reset.
   `CFIR_ASSERT_NR(a_reset_idle, clock, reset |=> !rsp_tvalid, "result offered after reset")

   // Coefficient loads and record starts never produce a result.
   `CFIR_ASSERT(a_ctrl_silent, clock, reset, req_tvalid && req_tready && !rsp_tvalid && (req_tuser == cfir_pkg::ACT_LOAD || req_tuser == cfir_pkg::ACT_START) |=> !rsp_tvalid, "result after load or start")

endmodule

bind centered_fir_filter cfir_checker u_cfir_checker (.*);
